### hdl/lru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU page replacement unit.
// No dependencies; compiled first.
package lru_pkg;

  // Width of the request and miss counters
  localparam int unsigned CNT_BITS = 32;

  // Frame count register
  localparam int unsigned NUM_FRAMES_BITS = 5;
  localparam logic [NUM_FRAMES_BITS-1:0] NUM_FRAMES_RESET = 5'd16;

  // Per-cell control, driven by the top level every cycle
  typedef struct packed {
    logic en;     // a request word is being taken this cycle
    logic take;   // load the neighbour's entry (cell 0: the request page)
    logic valid;  // valid mark after this request
  } lru_cell_ctl_t;

endpackage

### hdl/lru_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and frame-count config.
// Depends on lru_pkg for the counter and frame-count widths.

// Request channel: one page number per word
interface lru_req_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

// Response channel: one result word per request
interface lru_rsp_if #(
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned OCC_BITS  = 5
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          evict_valid;
  logic [PAGE_BITS-1:0]          evicted_page;
  logic [OCC_BITS-1:0]           occupancy;
  logic [lru_pkg::CNT_BITS-1:0]  request_count;
  logic [lru_pkg::CNT_BITS-1:0]  miss_count;
  logic [lru_pkg::CNT_BITS-1:0]  hit_count;

  modport source (output valid, output hit, output evict_valid, output evicted_page,
                  output occupancy, output request_count, output miss_count,
                  output hit_count, input ready);
  modport sink   (input valid, input hit, input evict_valid, input evicted_page,
                  input occupancy, input request_count, input miss_count,
                  input hit_count, output ready);
endinterface

// Configuration channel: frame count write
interface lru_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lru_pkg::NUM_FRAMES_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/lru_cell.sv
`timescale 1ns / 1ps
// One slot of the recency stack: page entry, valid mark and tag compare.
// Depends on lru_pkg for the control struct.
module lru_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lru_pkg::lru_cell_ctl_t ctl,
  input  logic [PAGE_BITS-1:0]   req_page,
  input  logic [PAGE_BITS-1:0]   prev_data,
  output logic [PAGE_BITS-1:0]   data,
  output logic                   valid,
  output logic                   match
);
  import lru_pkg::*;

  // Entry payload, no reset: only read behind the valid mark
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.take) begin
      data <= prev_data;
    end
  end

  // Valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
  end

  // Local tag compare
  assign match = valid && (data == req_page);

endmodule

### hdl/lru_sat_ctr.sv
`timescale 1ns / 1ps
// Saturating event counter.
// Depends on lru_pkg for the counter width.
module lru_sat_ctr (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         inc,
  output logic [lru_pkg::CNT_BITS-1:0] count
);
  import lru_pkg::*;

  // Count up, hold at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (inc && (count != {CNT_BITS{1'b1}})) begin
      count <= count + 1'b1;
    end
  end

endmodule

### hdl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
// LRU page replacement unit, fully associative. The recency stack is a row of
// FRAME_DEPTH cells, most recent page in cell 0. A request word is compared
// against every valid cell at once and the stack shifts by one cell in the same
// cycle; this combinational tag compare and one-step shift let the unit take one
// request per clock unless the output register is full and not being read out.
// Results are registered in the cycle after acceptance, and the next request is
// taken while a result is read out. The frame count register (1 to FRAME_DEPTH,
// 0 acts as 1, larger values act as FRAME_DEPTH) must be written only while idle;
// the block does not enforce it; after reset the stack is empty, no clearing pass.
// Depends on lru_pkg, lru_ifs, lru_cell and lru_sat_ctr.
module lru_page_replacement_unit #(
  parameter int unsigned FRAME_DEPTH = 16,
  parameter int unsigned PAGE_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  lru_cfg_if.sink   cfg,
  lru_req_if.sink   req,
  lru_rsp_if.source rsp
);
  import lru_pkg::*;

  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned LW = (CW > NUM_FRAMES_BITS) ? CW : NUM_FRAMES_BITS;

  logic [NUM_FRAMES_BITS-1:0] num_frames;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       out_valid;
  logic                       out_hit;
  logic                       out_evict;
  logic [PAGE_BITS-1:0]       out_evicted;

  logic                       accept;
  logic [FRAME_DEPTH-1:0]     match;
  logic [FRAME_DEPTH-1:0]     upper_hit;
  logic [FRAME_DEPTH:0]       valid_ext;
  logic [FRAME_DEPTH-1:0]     last_valid;
  logic [PAGE_BITS-1:0]       cell_data [FRAME_DEPTH];
  logic [PAGE_BITS-1:0]       evicted_sel;
  lru_cell_ctl_t              cell_ctl [FRAME_DEPTH];
  logic                       hit;
  logic                       evict;
  logic [LW-1:0]              limit;
  logic [LW-1:0]              nf_w;
  logic [CNT_BITS-1:0]        req_cnt;
  logic [CNT_BITS-1:0]        miss_cnt;

  // Handshakes: output register frees up when its word is taken
  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  // Frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      num_frames <= cfg.data;
    end
  end

  // Effective frame limit
  always_comb begin
    nf_w = LW'(num_frames);
    if (nf_w == '0) begin
      limit = LW'(1);
    end else if (nf_w > LW'(FRAME_DEPTH)) begin
      limit = LW'(FRAME_DEPTH);
    end else begin
      limit = nf_w;
    end
  end

  // Cell row
  assign valid_ext[FRAME_DEPTH] = 1'b0;
  for (genvar i = 0; i < FRAME_DEPTH; i++) begin : g_cell
    lru_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .req_page  (req.page_number),
      .prev_data ((i == 0) ? req.page_number : cell_data[(i == 0) ? 0 : i - 1]),
      .data      (cell_data[i]),
      .valid     (valid_ext[i]),
      .match     (match[i])
    );

    // Any match in a more recent cell
    if (i == 0) begin : g_top
      assign upper_hit[i] = 1'b0;
    end else begin : g_rest
      assign upper_hit[i] = |match[i-1:0];
    end

    // Least recent valid cell (valid marks form a thermometer)
    assign last_valid[i] = valid_ext[i] && !valid_ext[i+1];
  end

  // Hit, eviction and new occupancy
  assign hit   = |match;
  assign evict = !hit && (LW'(count) >= limit) && (count != '0);

  always_comb begin
    if (hit || evict) begin
      count_next = count;
    end else begin
      count_next = count + 1'b1;
    end
  end

  // Evicted page: one-hot select of the least recent cell
  always_comb begin
    evicted_sel = '0;
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      evicted_sel = evicted_sel | (cell_data[i] & {PAGE_BITS{last_valid[i]}});
    end
  end

  // Cell control: hit shifts cells up to the hit slot, miss shifts the whole
  // resident part (one slot longer unless a page is dropped)
  always_comb begin
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      cell_ctl[i].en = accept;
      if (hit) begin
        cell_ctl[i].valid = valid_ext[i];
        cell_ctl[i].take  = !upper_hit[i];
      end else if (evict) begin
        cell_ctl[i].valid = valid_ext[i];
        cell_ctl[i].take  = valid_ext[i];
      end else begin
        cell_ctl[i].valid = (i == 0) ? 1'b1 : valid_ext[(i == 0) ? 0 : i - 1];
        cell_ctl[i].take  = cell_ctl[i].valid;
      end
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Request and miss counters
  lru_sat_ctr u_req_ctr (
    .clk   (clk),
    .rst   (rst),
    .inc   (accept),
    .count (req_cnt)
  );

  lru_sat_ctr u_miss_ctr (
    .clk   (clk),
    .rst   (rst),
    .inc   (accept && !hit),
    .count (miss_cnt)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit     <= hit;
      out_evict   <= evict;
      out_evicted <= evict ? evicted_sel : '0;
    end
  end

  // Result word; counters and occupancy only move when the word is replaced
  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.evict_valid   = out_evict;
  assign rsp.evicted_page  = out_evicted;
  assign rsp.occupancy     = count;
  assign rsp.request_count = req_cnt;
  assign rsp.miss_count    = miss_cnt;
  assign rsp.hit_count     = req_cnt - miss_cnt;

endmodule
